// ===== hdl/uart_register_block_defines.svh =====
// Assertion macros for the UART register block.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef UART_REGISTER_BLOCK_DEFINES_SVH
`define UART_REGISTER_BLOCK_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define URB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uart_register_block: assertion failed");

// Check a plain condition on every clock edge outside reset.
`define URB_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("uart_register_block: invariant violated");

`endif

// ===== hdl/uart_rb_pkg.sv =====
// Shared types, status bit masks, register indexes and helpers for the UART register block.
// No dependencies.
package uart_rb_pkg;

  localparam int FRAME_BITS_DEF = 11;
  localparam int CNT_W          = 36;
  localparam int DATA_W         = 32;

  typedef enum logic [1:0] {
    CMD_READ      = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_LINE_BYTE = 2'd2,
    CMD_TICK      = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_RXDATA  = 3'd0;
  localparam logic [2:0] REG_TXDATA  = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_CONTROL = 3'd3;
  localparam logic [2:0] REG_DIVISOR = 3'd4;

  localparam logic [DATA_W-1:0] ST_PE     = 32'h001;
  localparam logic [DATA_W-1:0] ST_FE     = 32'h002;
  localparam logic [DATA_W-1:0] ST_BRK    = 32'h004;
  localparam logic [DATA_W-1:0] ST_ROE    = 32'h008;
  localparam logic [DATA_W-1:0] ST_TOE    = 32'h010;
  localparam logic [DATA_W-1:0] ST_TMT    = 32'h020;
  localparam logic [DATA_W-1:0] ST_TRDY   = 32'h040;
  localparam logic [DATA_W-1:0] ST_RRDY   = 32'h080;
  localparam logic [DATA_W-1:0] ST_E      = 32'h100;
  localparam logic [DATA_W-1:0] ST_ERRORS = ST_PE | ST_FE | ST_BRK | ST_ROE | ST_TOE;
  localparam logic [DATA_W-1:0] ST_RESET  = ST_TRDY | ST_TMT;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  line_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
  } result_t;

  // Set status bits and raise E whenever any error bit is set.
  function automatic logic [DATA_W-1:0] set_bits(input logic [DATA_W-1:0] st,
                                                 input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] r;
    r = st | m;
    if ((r & ST_ERRORS) != '0) begin
      r = r | ST_E;
    end
    return r;
  endfunction

endpackage

// ===== hdl/uart_rb_core.sv =====
// UART register state and single-pass update logic for one item.
// Depends on uart_rb_pkg.
module uart_rb_core #(
  parameter int FRAME_BITS = uart_rb_pkg::FRAME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  uart_rb_pkg::item_t   item,
  output uart_rb_pkg::result_t result
);
  import uart_rb_pkg::*;

  localparam logic [CNT_W-1:0] FRAME_LEN_RESET = CNT_W'(2 * FRAME_BITS);

  logic [DATA_W-1:0] status_reg,  status_next;
  logic [DATA_W-1:0] control_reg, control_next;
  logic [DATA_W-1:0] divisor_reg, divisor_next;
  logic [CNT_W-1:0]  frame_len,   frame_len_next;
  logic [7:0]        rx_holding,  rx_holding_next;
  logic [7:0]        tx_holding,  tx_holding_next;
  logic [7:0]        rx_shift,    rx_shift_next;
  logic [7:0]        tx_shift,    tx_shift_next;
  logic              rx_free,     rx_free_next;
  logic [CNT_W-1:0]  rx_countdown, rx_countdown_next;
  logic [CNT_W-1:0]  tx_countdown, tx_countdown_next;
  logic [31:0]       rdata;
  logic              txv;
  logic [7:0]        txb;

  always_comb begin
    status_next       = status_reg;
    control_next      = control_reg;
    divisor_next      = divisor_reg;
    frame_len_next    = frame_len;
    rx_holding_next   = rx_holding;
    tx_holding_next   = tx_holding;
    rx_shift_next     = rx_shift;
    tx_shift_next     = tx_shift;
    rx_free_next      = rx_free;
    rx_countdown_next = rx_countdown;
    tx_countdown_next = tx_countdown;
    rdata             = '0;
    txv               = 1'b0;
    txb               = '0;

    case (item.cmd)
      CMD_READ: begin
        case (item.reg_index)
          REG_RXDATA: begin
            rdata       = {24'd0, rx_holding};
            status_next = status_reg & ~ST_RRDY;
          end
          REG_STATUS:  rdata = status_reg;
          REG_CONTROL: rdata = control_reg;
          REG_DIVISOR: rdata = divisor_reg;
          default:     rdata = '0;
        endcase
      end
      CMD_WRITE: begin
        case (item.reg_index)
          REG_TXDATA: begin
            tx_holding_next = item.write_data[7:0];
            if ((status_reg & ST_TMT) != '0) begin
              status_next       = set_bits(status_reg & ~ST_TMT, ST_TRDY);
              tx_shift_next     = item.write_data[7:0];
              tx_countdown_next = frame_len;
            end else if ((status_reg & ST_TRDY) == '0) begin
              status_next = set_bits(status_reg, ST_TOE);
            end else begin
              status_next = status_reg & ~ST_TRDY;
            end
          end
          REG_STATUS:  status_next = item.write_data;
          REG_CONTROL: control_next = item.write_data;
          REG_DIVISOR: begin
            divisor_next   = item.write_data;
            // Precompute frame length so frame starts see a plain register.
            frame_len_next = CNT_W'((CNT_W'(item.write_data) + CNT_W'(1))
                                    * CNT_W'(FRAME_BITS));
          end
          default: ;
        endcase
      end
      CMD_LINE_BYTE: begin
        if (rx_free) begin
          rx_shift_next     = item.line_byte;
          rx_free_next      = 1'b0;
          rx_countdown_next = frame_len;
        end
      end
      CMD_TICK: begin
        // Receive side completes first when both expire together.
        if (rx_countdown != '0) begin
          rx_countdown_next = rx_countdown - CNT_W'(1);
          if (rx_countdown_next == '0) begin
            rx_holding_next = rx_shift;
            rx_free_next    = 1'b1;
            if ((status_next & ST_RRDY) != '0) begin
              status_next = set_bits(status_next, ST_ROE);
            end else begin
              status_next = set_bits(status_next, ST_RRDY);
            end
          end
        end
        if (tx_countdown != '0) begin
          tx_countdown_next = tx_countdown - CNT_W'(1);
          if (tx_countdown_next == '0) begin
            txv = 1'b1;
            txb = tx_shift;
            if ((status_next & ST_TRDY) == '0) begin
              status_next       = set_bits(status_next & ~ST_TMT, ST_TRDY);
              tx_shift_next     = tx_holding;
              tx_countdown_next = frame_len;
            end else begin
              status_next = set_bits(status_next, ST_TMT);
            end
          end
        end
      end
      default: ;
    endcase

    result.read_data = rdata;
    result.tx_valid  = txv;
    result.tx_byte   = txb;
    result.irq       = (control_next & status_next) != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_reg   <= ST_RESET;
      control_reg  <= '0;
      divisor_reg  <= DATA_W'(1);
      frame_len    <= FRAME_LEN_RESET;
      rx_holding   <= '0;
      tx_holding   <= '0;
      rx_shift     <= '0;
      tx_shift     <= '0;
      rx_free      <= 1'b1;
      rx_countdown <= '0;
      tx_countdown <= '0;
    end else if (en) begin
      status_reg   <= status_next;
      control_reg  <= control_next;
      divisor_reg  <= divisor_next;
      frame_len    <= frame_len_next;
      rx_holding   <= rx_holding_next;
      tx_holding   <= tx_holding_next;
      rx_shift     <= rx_shift_next;
      tx_shift     <= tx_shift_next;
      rx_free      <= rx_free_next;
      rx_countdown <= rx_countdown_next;
      tx_countdown <= tx_countdown_next;
    end
  end

endmodule

// ===== hdl/uart_register_block.sv =====
// UART register block top level: input register, update core, result register.
// Throughput 1 item per cycle while the output is not stalled; with m_tvalid high and m_tready
// low, both the input register and the result register hold their contents.
// The core updates all state in the cycle an item moves from the input to the result register.
// Reset (rst, synchronous) empties both registers and loads status 0x60, divisor 1.
// Depends on uart_rb_pkg, uart_rb_core and uart_register_block_defines.svh.
`include "uart_register_block_defines.svh"
module uart_register_block #(
  parameter int FRAME_BITS = uart_rb_pkg::FRAME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: reg_index[2:0], write_data[34:3], line_byte[42:35], zero fill
  input  logic [47:0] s_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: read_data[31:0], tx_valid[32], tx_byte[40:33], irq[41], zero fill
  output logic [47:0] m_tdata
);
  import uart_rb_pkg::*;

  logic    in_v;
  item_t   in_item;
  logic    adv;
  result_t core_result;
  result_t out_result;

  assign adv      = in_v && (!m_tvalid || m_tready);
  assign s_tready = !in_v || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd        <= cmd_t'(s_tuser);
      in_item.reg_index  <= s_tdata[2:0];
      in_item.write_data <= s_tdata[34:3];
      in_item.line_byte  <= s_tdata[42:35];
    end
  end

  uart_rb_core #(
    .FRAME_BITS(FRAME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .item   (in_item),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {6'd0, out_result.irq, out_result.tx_byte,
                    out_result.tx_valid, out_result.read_data};

  `URB_ASSERT(a_stall_means_full, !s_tready |-> in_v)
  `URB_ASSERT(a_adv_fills_output, adv |=> m_tvalid)
  `URB_ASSERT_ALWAYS(a_tx_only_on_tick,
    !m_tvalid || !out_result.tx_valid || (out_result.read_data == '0))
  `URB_ASSERT_ALWAYS(a_tx_byte_zero_when_idle,
    !m_tvalid || out_result.tx_valid || (out_result.tx_byte == '0))

endmodule
